// ----- rtl/bfm_pkg.sv -----
// bfm_pkg: shared constants and codes for the bloom filter block.
// No dependencies; used by the channel interfaces and the top level.
package bfm_pkg;

   // hash constants
   localparam logic [63:0] MUR_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MUR_SHIFT = 47;

   // payload widths
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned KEY_WORD_W = 64;
   localparam int unsigned WBYTES_W   = 4;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_NONE  = 2'd3;

   // register map
   localparam int unsigned CSR_AW = 3;
   localparam logic REG_NUM_BITS   = 1'b0;
   localparam logic REG_NUM_HASHES = 1'b1;
   localparam int unsigned NUM_BITS_W   = 17;
   localparam int unsigned NUM_HASHES_W = 6;
   localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 17'd65536;
   localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 6'd7;

   // parameter defaults
   localparam int unsigned ARRAY_BITS_DEF    = 65536;
   localparam int unsigned MAX_KEY_WORDS_DEF = 8;
   localparam int unsigned MAX_HASHES_DEF    = 32;

endpackage

// ----- rtl/bfm_chan_if.sv -----
// bfm_chan_if: request and response channel interfaces (valid/ready).
// Depends on bfm_pkg for payload widths.
interface bfm_req_if;
   import bfm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [KEY_WORD_W-1:0] key_word;
   logic [WBYTES_W-1:0]   word_bytes;
   logic                  last_word;
   modport source (output valid, req_type, key_word, word_bytes, last_word, input ready);
   modport sink   (input valid, req_type, key_word, word_bytes, last_word, output ready);
endinterface

interface bfm_rsp_if;
   logic valid;
   logic ready;
   logic maybe_present;
   logic status;
   modport source (output valid, maybe_present, status, input ready);
   modport sink   (input valid, maybe_present, status, output ready);
endinterface

// ----- rtl/bloom_filter_murmur64a.sv -----
// bloom_filter_murmur64a: bloom filter with MurmurHash64A double hashing.
// Depends on bfm_pkg and the channel interfaces in bfm_chan_if.sv.
//
//   channel   dir   beat contents                                  accepted when
//   req_ch    in    req_type, key_word, word_bytes, last_word      valid & ready
//   rsp_ch    out   maybe_present, status                          valid & ready
//   csr (APB) in    num_bits @ 0x0, num_hashes @ 0x4               psel&penable&pwrite
//
// A word that is not last leaves the block ready for the next beat. A last
// word runs two hash passes on one shared 32x32 multiplier that forms each
// 64-bit product from partial products, then a bit-serial modulo and an
// array read-modify-write for each probe.
// Reset and clear sweep the bit array one 64-bit row a cycle, ready low.
// req_ch.ready is low from a last word until its response beat is taken.
module bloom_filter_murmur64a #(
   parameter int unsigned ARRAY_BITS    = bfm_pkg::ARRAY_BITS_DEF,
   parameter int unsigned MAX_KEY_WORDS = bfm_pkg::MAX_KEY_WORDS_DEF,
   parameter int unsigned MAX_HASHES    = bfm_pkg::MAX_HASHES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   bfm_req_if.sink                     req_ch,
   bfm_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bfm_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import bfm_pkg::*;

   localparam int unsigned KEY_CAP = MAX_KEY_WORDS * 8;
   localparam int unsigned LEN_W   = $clog2(KEY_CAP + 9);
   localparam int unsigned KW_W    = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
   localparam int unsigned WC_W    = $clog2(MAX_KEY_WORDS + 1);
   localparam int unsigned ROWS    = (ARRAY_BITS + 63) / 64;
   localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned PI_W    = $clog2(MAX_HASHES + 1);
   localparam int unsigned NB_CAP  = (ARRAY_BITS < 65536) ? ARRAY_BITS : 65536;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_MUL, S_LEN, S_WORD, S_KLOAD, S_KMIX, S_KDONE, S_HDONE,
      S_TDONE, S_FMIX, S_FDONE, S_DIV, S_ROWRD, S_ROWCHK, S_RESP
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   // control
   logic [LEN_W-1:0]      key_len_ff, key_len_in, hlen_ff, hlen_in;
   logic                  tl_ff, tl_in;
   logic [63:0]           stage_ff, stage_in;
   logic [1:0]            mph_ff, mph_in;
   logic                  pass_ff, pass_in;
   logic [WC_W-1:0]       wcnt_ff, wcnt_in;
   logic [PI_W-1:0]       pi_ff, pi_in;
   logic [5:0]            bcnt_ff, bcnt_in;
   logic [ROW_W-1:0]      clr_row_ff, clr_row_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic                  is_add_ff, is_add_in;
   logic                  present_ff, present_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_mp_ff, rsp_mp_in;
   logic                  rsp_st_ff, rsp_st_in;
   // datapath
   logic [63:0]           mop_ff, mop_in, acc_ff, acc_in, h_ff, h_in;
   logic [63:0]           h1_ff, h1_in, h2_ff, h2_in, p_ff, p_in, dsh_ff, dsh_in;
   logic [16:0]           rem_ff, rem_in;
   // config registers
   logic [NUM_BITS_W-1:0]   num_bits_ff;
   logic [NUM_HASHES_W-1:0] num_hashes_ff;

   // memories
   logic [63:0]           key_mem [MAX_KEY_WORDS];
   logic [63:0]           key_rd_ff;
   logic                  key_we;
   logic [KW_W-1:0]       key_wa, key_ra;
   logic [63:0]           key_wd;
   logic [63:0]           arr_mem [ROWS];
   logic [63:0]           arr_rd_ff;
   logic                  arr_we;
   logic [ROW_W-1:0]      arr_wa, arr_ra;
   logic [63:0]           arr_wd;

   // shared multiplier: one 32x32 partial product per cycle
   logic [31:0]           mul_a, mul_b;
   logic [63:0]           prod;

   // misc combinational
   logic                  req_acc;
   logic [3:0]            nb_c;
   logic [63:0]           mw;
   logic [127:0]          sh;
   logic [LEN_W-1:0]      sum;
   logic                  ovf;
   logic [16:0]           n_eff;
   logic [PI_W-1:0]       k_eff;
   logic [17:0]           trial;
   logic [63:0]           hv, seed;
   logic [ROW_W-1:0]      row;
   logic                  cfg_wr;

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign req_acc           = req_ch.valid & req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.maybe_present = rsp_mp_ff;
   assign rsp_ch.status     = rsp_st_ff;

   // APB register file
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_NUM_HASHES) ? {26'd0, num_hashes_ff}
                                                : {15'd0, num_bits_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff   <= NUM_BITS_RST;
         num_hashes_ff <= NUM_HASHES_RST;
      end else if (cfg_wr) begin
         if (paddr[2] == REG_NUM_BITS) num_bits_ff <= pwdata[NUM_BITS_W-1:0];
         else                          num_hashes_ff <= pwdata[NUM_HASHES_W-1:0];
      end
   end

   // effective modulus and probe count
   always_comb begin
      if (num_bits_ff == '0)                  n_eff = 17'd1;
      else if (num_bits_ff > 17'(NB_CAP))     n_eff = 17'(NB_CAP);
      else                                    n_eff = num_bits_ff;
      if (num_hashes_ff == '0)                            k_eff = PI_W'(1);
      else if ({1'b0, num_hashes_ff} > 7'(MAX_HASHES))    k_eff = PI_W'(MAX_HASHES);
      else                                                k_eff = PI_W'(num_hashes_ff);
   end

   // partial product select: lo*lo, hi*lo, lo*hi
   assign mul_a = (mph_ff == 2'd1) ? mop_ff[63:32] : mop_ff[31:0];
   assign mul_b = (mph_ff == 2'd2) ? MUR_MUL[63:32] : MUR_MUL[31:0];
   assign prod  = 64'(mul_a) * 64'(mul_b);

   // key word packing
   always_comb begin
      nb_c = (req_ch.word_bytes > 4'd8) ? 4'd8 : req_ch.word_bytes;
      for (int b = 0; b < 8; b++)
         mw[8*b +: 8] = (4'(b) < nb_c) ? req_ch.key_word[8*b +: 8] : 8'd0;
      sh    = {64'd0, mw} << {key_len_ff[2:0], 3'd0};
      sum   = key_len_ff + LEN_W'(nb_c);
      ovf   = tl_ff | (sum > LEN_W'(KEY_CAP));
      trial = {rem_ff, dsh_ff[63]};
      hv    = acc_ff ^ (acc_ff >> MUR_SHIFT);
      seed  = pass_ff ? {32'd0, h1_ff[31:0]} : 64'd0;
      row   = ROW_W'(rem_ff >> 6);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;     ret_in = ret_ff;
      key_len_in = key_len_ff; hlen_in = hlen_ff; tl_in = tl_ff; stage_in = stage_ff;
      mph_in = mph_ff;         pass_in = pass_ff; wcnt_in = wcnt_ff; pi_in = pi_ff;
      bcnt_in = bcnt_ff;       clr_row_in = clr_row_ff; clr_rsp_in = clr_rsp_ff;
      is_add_in = is_add_ff;   present_in = present_ff;
      rsp_valid_in = rsp_valid_ff; rsp_mp_in = rsp_mp_ff; rsp_st_in = rsp_st_ff;
      mop_in = mop_ff; acc_in = acc_ff; h_in = h_ff; h1_in = h1_ff; h2_in = h2_ff;
      p_in = p_ff; dsh_in = dsh_ff; rem_in = rem_ff;
      key_we = 1'b0; key_wa = KW_W'(key_len_ff >> 3); key_wd = stage_ff | sh[63:0];
      key_ra = KW_W'(wcnt_ff);
      arr_we = 1'b0; arr_wa = row; arr_wd = 64'd0; arr_ra = row;

      unique case (state_ff)
         S_CLR: begin
            arr_we = 1'b1;
            arr_wa = clr_row_ff;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1; rsp_mp_in = 1'b1; rsp_st_in = 1'b0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               case (req_ch.req_type)
                  REQ_NONE: ;
                  REQ_CLEAR: begin
                     clr_row_in = '0; clr_rsp_in = 1'b1;
                     key_len_in = '0; tl_in = 1'b0; stage_in = 64'd0;
                     state_in = S_CLR;
                  end
                  default: begin
                     is_add_in = (req_ch.req_type == REQ_ADD);
                     if (ovf) begin
                        tl_in = 1'b1;
                     end else begin
                        key_len_in = sum;
                        if ({1'b0, key_len_ff[2:0]} + nb_c >= 4'd8) begin
                           key_we   = 1'b1;
                           stage_in = sh[127:64];
                        end else begin
                           stage_in = stage_ff | sh[63:0];
                        end
                     end
                     if (req_ch.last_word) begin
                        key_len_in = '0; tl_in = 1'b0;
                        if (ovf) begin
                           stage_in = 64'd0;
                           rsp_valid_in = 1'b1; rsp_mp_in = 1'b0; rsp_st_in = 1'b1;
                           state_in = S_RESP;
                        end else begin
                           hlen_in = sum; pass_in = 1'b0;
                           mop_in = 64'(sum); ret_in = S_LEN; mph_in = 2'd0;
                           state_in = S_MUL;
                        end
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            acc_in = (mph_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
            if (mph_ff == 2'd2) begin
               mph_in = 2'd0; state_in = ret_ff;
            end else begin
               mph_in = mph_ff + 2'd1;
            end
         end
         S_LEN: begin
            h_in = seed ^ acc_ff; wcnt_in = '0; state_in = S_WORD;
         end
         S_WORD: begin
            if (LEN_W'(wcnt_ff) < (hlen_ff >> 3)) begin
               state_in = S_KLOAD;
            end else if (hlen_ff[2:0] != 3'd0) begin
               mop_in = h_ff ^ stage_ff; ret_in = S_TDONE; state_in = S_MUL;
            end else begin
               state_in = S_FMIX;
            end
         end
         S_KLOAD: begin
            mop_in = key_rd_ff; ret_in = S_KMIX; state_in = S_MUL;
         end
         S_KMIX: begin
            mop_in = hv; ret_in = S_KDONE; state_in = S_MUL;
         end
         S_KDONE: begin
            mop_in = h_ff ^ acc_ff; ret_in = S_HDONE; state_in = S_MUL;
         end
         S_HDONE: begin
            h_in = acc_ff; wcnt_in = wcnt_ff + 1'b1; state_in = S_WORD;
         end
         S_TDONE: begin
            h_in = acc_ff; state_in = S_FMIX;
         end
         S_FMIX: begin
            mop_in = h_ff ^ (h_ff >> MUR_SHIFT); ret_in = S_FDONE; state_in = S_MUL;
         end
         S_FDONE: begin
            if (!pass_ff) begin
               h1_in = hv; pass_in = 1'b1;
               mop_in = 64'(hlen_ff); ret_in = S_LEN; state_in = S_MUL;
            end else begin
               h2_in = hv; p_in = h1_ff; dsh_in = h1_ff; rem_in = '0; bcnt_in = '0;
               pi_in = '0; stage_in = 64'd0; present_in = 1'b1; state_in = S_DIV;
            end
         end
         // restoring reduction, one dividend bit per cycle
         S_DIV: begin
            rem_in  = (trial >= {1'b0, n_eff}) ? 17'(trial - {1'b0, n_eff}) : trial[16:0];
            dsh_in  = dsh_ff << 1;
            bcnt_in = bcnt_ff + 6'd1;
            if (bcnt_ff == 6'd63) state_in = S_ROWRD;
         end
         S_ROWRD: begin
            state_in = S_ROWCHK;
         end
         S_ROWCHK: begin
            if (is_add_ff) begin
               arr_we = 1'b1;
               arr_wd = arr_rd_ff | (64'd1 << rem_ff[5:0]);
            end else if (!arr_rd_ff[rem_ff[5:0]]) begin
               present_in = 1'b0;
            end
            if (pi_ff + 1'b1 == k_eff) begin
               rsp_valid_in = 1'b1;
               rsp_mp_in    = is_add_ff | (present_ff & arr_rd_ff[rem_ff[5:0]]);
               rsp_st_in    = 1'b0;
               state_in     = S_RESP;
            end else begin
               pi_in = pi_ff + 1'b1; p_in = p_ff + h2_ff; dsh_in = p_ff + h2_ff;
               rem_in = '0; bcnt_in = '0; state_in = S_DIV;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;     ret_ff <= S_IDLE;
         key_len_ff <= '0;      tl_ff <= 1'b0;     stage_ff <= 64'd0;
         mph_ff <= 2'd0;        pass_ff <= 1'b0;   clr_row_ff <= '0;
         clr_rsp_ff <= 1'b0;    rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  ret_ff <= ret_in;
         key_len_ff <= key_len_in; tl_ff <= tl_in; stage_ff <= stage_in;
         mph_ff <= mph_in;      pass_ff <= pass_in; clr_row_ff <= clr_row_in;
         clr_rsp_ff <= clr_rsp_in; rsp_valid_ff <= rsp_valid_in;
      end
      hlen_ff <= hlen_in;  wcnt_ff <= wcnt_in;  pi_ff <= pi_in;   bcnt_ff <= bcnt_in;
      is_add_ff <= is_add_in; present_ff <= present_in;
      rsp_mp_ff <= rsp_mp_in; rsp_st_ff <= rsp_st_in;
      mop_ff <= mop_in; acc_ff <= acc_in; h_ff <= h_in; h1_ff <= h1_in; h2_ff <= h2_in;
      p_ff <= p_in; dsh_ff <= dsh_in; rem_ff <= rem_in;
   end

   // key buffer
   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_wd;
      key_rd_ff <= key_mem[key_ra];
   end

   // bit array, 64 bits per row
   always_ff @(posedge clock) begin
      if (arr_we) arr_mem[arr_wa] <= arr_wd;
      arr_rd_ff <= arr_mem[arr_ra];
   end

   // checks
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready) else $error("request taken with response pending");
   a_status_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status) |-> !rsp_ch.maybe_present)
      else $error("overlong key reported present");
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.req_type == REQ_CLEAR) |=> (state_ff == S_CLR && clr_row_ff == '0))
      else $error("clear did not start sweep");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (state_ff == S_RESP))
      else $error("response dropped while stalled");

endmodule

// ----- verif/bfm_checker.sv -----
// bfm_checker: watches the request and response channels of the bloom filter,
// predicts each response from its own copy of the filter state and compares.
// Depends on bfm_pkg and the channel interfaces in bfm_chan_if.sv.
`timescale 1ns / 1ps
module bfm_checker (
   input  logic        clock,
   input  logic        reset,
   bfm_req_if.sink     req_ch,
   bfm_rsp_if.sink     rsp_ch,
   input  logic [16:0] cfg_num_bits,
   input  logic [5:0]  cfg_num_hashes,
   output int          fail_count,
   output int          pending
);
   import bfm_pkg::*;

   typedef struct packed {
      logic maybe_present;
      logic status;
   } verdict_type;

   verdict_type verdict_q[$];
   logic [7:0]  key_bytes[64];
   int          key_len;
   logic        overflow;
   bit          filter_bits[65536];
   int          mismatches;

   // MurmurHash64A over the collected key bytes
   function automatic logic [63:0] murmur(input int len, input logic [63:0] seed);
      logic [63:0] h, k;
      int          nw, tail;
      h    = seed ^ (64'(len) * MUR_MUL);
      nw   = len / 8;
      tail = len % 8;
      for (int w = 0; w < nw; w++) begin
         k = '0;
         for (int b = 0; b < 8; b++) k[8*b +: 8] = key_bytes[8*w+b];
         k = k * MUR_MUL;
         k = k ^ (k >> MUR_SHIFT);
         k = k * MUR_MUL;
         h = (h ^ k) * MUR_MUL;
      end
      if (tail != 0) begin
         k = '0;
         for (int b = 0; b < tail; b++) k[8*b +: 8] = key_bytes[8*nw+b];
         h = (h ^ k) * MUR_MUL;
      end
      h = h ^ (h >> MUR_SHIFT);
      h = h * MUR_MUL;
      h = h ^ (h >> MUR_SHIFT);
      return h;
   endfunction

   // update filter state with one request beat; queue expected response if any
   task automatic filter_step(input logic [1:0] rt, input logic [63:0] kw,
                              input logic [3:0] nb_in, input logic lw);
      int          nb, nbits, k;
      logic [63:0] h1, h2, idx;
      logic        present;
      verdict_type v;
      if (rt == REQ_NONE) return;
      if (rt == REQ_CLEAR) begin
         foreach (filter_bits[i]) filter_bits[i] = 0;
         key_len  = 0;
         overflow = 0;
         v.maybe_present = 1;
         v.status        = 0;
         verdict_q = {verdict_q, v};
         return;
      end
      nb = (nb_in > 8) ? 8 : nb_in;
      if (overflow || key_len + nb > 64) overflow = 1;
      else begin
         for (int b = 0; b < nb; b++) key_bytes[key_len+b] = kw[8*b +: 8];
         key_len += nb;
      end
      if (!lw) return;
      if (overflow) begin
         v.maybe_present = 0;
         v.status        = 1;
      end else begin
         nbits = (cfg_num_bits == 0) ? 1 : (cfg_num_bits > 65536 ? 65536 : cfg_num_bits);
         k     = (cfg_num_hashes == 0) ? 1 : (cfg_num_hashes > 32 ? 32 : cfg_num_hashes);
         h1 = murmur(key_len, 64'd0);
         h2 = murmur(key_len, {32'd0, h1[31:0]});
         present = 1;
         for (int i = 0; i < k; i++) begin
            idx = (h1 + 64'(i) * h2) % 64'(nbits);
            if (rt == REQ_ADD) filter_bits[idx] = 1;
            else if (!filter_bits[idx]) present = 0;
         end
         v.maybe_present = present;
         v.status        = 0;
      end
      key_len  = 0;
      overflow = 0;
      verdict_q = {verdict_q, v};
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      mismatches = 0;
      key_len    = 0;
      overflow   = 0;
      foreach (filter_bits[i]) filter_bits[i] = 0;
   end

   // sample both channels at each edge
   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            filter_step(req_ch.req_type, req_ch.key_word, req_ch.word_bytes,
                        req_ch.last_word);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat at %0t", $realtime);
            end else begin
               want = verdict_q.pop_front();
               if (want.maybe_present !== rsp_ch.maybe_present ||
                   want.status !== rsp_ch.status) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected present=%0b status=%0b, got %0b %0b",
                              $realtime, want.maybe_present, want.status,
                              rsp_ch.maybe_present, rsp_ch.status);
               end
            end
         end
      end
      pending = verdict_q.size();
   end
endmodule

// ----- verif/testbench.sv -----
// testbench: stimulus and verdict for bloom_filter_murmur64a.
// Depends on bfm_pkg, bfm_chan_if.sv, the block and bfm_checker.
`timescale 1ns / 1ps
module testbench;
   import bfm_pkg::*;

   logic              clock;
   logic              reset;
   logic              psel, penable, pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata, prdata;
   logic              pready;
   logic [16:0]       cur_bits;
   logic [5:0]        cur_hashes;
   int                fail_count, pending;
   int                items_sent, keys_sent;
   bit                calm;
   logic [63:0]       saved_key[8];

   bfm_req_if req_ch();
   bfm_rsp_if rsp_ch();

   bloom_filter_murmur64a dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bfm_checker u_chk (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.sink),
      .cfg_num_bits(cur_bits), .cfg_num_hashes(cur_hashes),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit, in case the test hangs
   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

   // response side stalls at random, except in calm stretches
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
   end

   // APB register write: setup then access
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == 3'(4 * REG_NUM_BITS)) cur_bits = data[16:0];
      else cur_hashes = data[5:0];
   endtask

   // send one request beat, with random idle before it; valid stays up after
   task automatic send_beat(input logic [1:0] rt, input logic [63:0] kw,
                            input logic [3:0] nb, input logic lw);
      while (!calm && $urandom_range(99) < 8) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.req_type <= rt; req_ch.key_word <= kw;
      req_ch.word_bytes <= nb; req_ch.last_word <= lw;
      @(posedge clock iff req_ch.ready);
      items_sent++;
      if (lw && rt != REQ_CLEAR && rt != REQ_NONE) keys_sent++;
   endtask

   // whole key of given byte length; short last word, full words before
   task automatic send_key(input logic [1:0] rt, input int len, input bit reuse);
      int          left, nb;
      logic [63:0] w;
      left = len;
      for (int i = 0; ; i++) begin
         nb = (left > 8) ? 8 : left;
         if (reuse && i < 8) w = saved_key[i];
         else w = {$urandom, $urandom};
         if (i < 8) saved_key[i] = w;
         left -= nb;
         send_beat(rt, w, 4'(nb), left == 0);
         if (left == 0) break;
      end
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   initial begin
      int len, r;
      items_sent = 0; keys_sent = 0; calm = 0;
      reset = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_ch.valid = 0; req_ch.req_type = REQ_ADD; req_ch.key_word = '0;
      req_ch.word_bytes = '0; req_ch.last_word = 0;
      cur_bits = NUM_BITS_RST; cur_hashes = NUM_HASHES_RST;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty key, full-width words, overflow, odd splits, ignored type
      send_beat(REQ_QUERY, '0, 4'd0, 1);
      send_beat(REQ_ADD, '0, 4'd0, 1);
      send_beat(REQ_QUERY, '0, 4'd0, 1);
      send_beat(REQ_ADD, '1, 4'd8, 1);
      send_beat(REQ_QUERY, '1, 4'd15, 1);
      send_beat(REQ_ADD, 64'h0123456789abcdef, 4'd3, 0);
      send_beat(REQ_ADD, 64'hfedcba9876543210, 4'd5, 1);
      send_beat(REQ_QUERY, 64'h0123456789abcdef, 4'd3, 0);
      send_beat(REQ_QUERY, 64'hfedcba9876543210, 4'd5, 1);
      for (int i = 0; i < 9; i++) send_beat(REQ_ADD, '1, 4'd8, i == 8);
      send_beat(REQ_NONE, '1, 4'd8, 1);
      send_beat(REQ_ADD, 64'h5a, 4'd1, 0);
      send_beat(REQ_CLEAR, '1, 4'd8, 1);
      send_beat(REQ_QUERY, '1, 4'd8, 1);
      drain();

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(3'(4*REG_NUM_BITS), 32'd1);
                  csr_write(3'(4*REG_NUM_HASHES), 32'd1); end
            1: begin csr_write(3'(4*REG_NUM_BITS), 32'd0);
                  csr_write(3'(4*REG_NUM_HASHES), 32'd0); end
            2: begin csr_write(3'(4*REG_NUM_BITS), 32'd131071);
                  csr_write(3'(4*REG_NUM_HASHES), 32'd63); end
            3: begin csr_write(3'(4*REG_NUM_BITS), 32'd65536);
                  csr_write(3'(4*REG_NUM_HASHES), 32'd32); end
            4: begin csr_write(3'(4*REG_NUM_BITS), 32'd97);
                  csr_write(3'(4*REG_NUM_HASHES), 32'd3); end
            default: begin csr_write(3'(4*REG_NUM_BITS), 32'($urandom_range(2, 4096)));
                  csr_write(3'(4*REG_NUM_HASHES), 32'($urandom_range(1, 12))); end
         endcase
         calm = (ph == 3);
         while (items_sent < 40 + (ph + 1) * 120) begin
            r = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 72) : $urandom_range(0, 20);
            if (r < 45) send_key(REQ_ADD, len, 0);
            else if (r < 65) send_key(REQ_QUERY, len, 0);
            else if (r < 82) begin
               // query a key just added, same words
               send_key(REQ_ADD, len, 0);
               send_key(REQ_QUERY, len, 1);
            end else if (r < 86) send_beat(REQ_CLEAR, {$urandom, $urandom}, 4'($urandom), 1'($urandom));
            else if (r < 90) send_beat(REQ_NONE, {$urandom, $urandom}, 4'($urandom), 1'($urandom));
            else send_beat(1'($urandom), {$urandom, $urandom}, 4'($urandom), 1'($urandom));
         end
         // close any open key before a register write
         send_beat(REQ_QUERY, '0, 4'd0, 1);
         drain();
      end

      $display("Sent %0d request beats forming %0d keys over six register settings.",
               items_sent, keys_sent);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/bfm_pkg.sv
rtl/bfm_chan_if.sv
rtl/bloom_filter_murmur64a.sv
verif/bfm_checker.sv
verif/testbench.sv
